FILE: rtl/cng_pkg.sv
// ----------------------------------------------------------------------------
// cng_pkg
// Shared widths, constants and controller/datapath command types for the
// colored noise generator.
// ----------------------------------------------------------------------------
package cng_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP   = 2'd2;

    // register fields
    localparam int COLOR_W = 2;
    localparam int SEED_W  = 32;
    localparam int AMP_W   = 17;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_PINK  = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_BROWN = 2'd2;
    localparam logic [COLOR_W-1:0] COLOR_NONE  = 2'd3;

    localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 17'd32768;

    // generator
    localparam logic [20:0]       LCG_MUL = 21'd1664525;
    localparam logic [SEED_W-1:0] LCG_INC = 32'd1013904223;

    // datapath widths
    localparam int DRAW_W   = 25;  // Q24 draw, -2^24 .. 2^24-2
    localparam int STEP_W   = 25;  // brown increment
    localparam int WALK_W   = 26;  // clamped walk, +-2^24
    localparam int V_W      = 27;  // colored value, up to 3*2^24
    localparam int U_W      = 29;  // scaled value before clamp
    localparam int UC_W     = 26;  // clamped scaled value
    localparam int QUOT_W   = 25;  // pink quotient magnitude
    localparam int SAMPLE_W = 16;

    localparam logic signed [15:0] BROWN_GAIN = 16'sd6554;
    localparam logic signed [15:0] PCM_GAIN   = 16'sd32767;

    typedef struct packed {
        logic load;       // item taken, restart applies here
        logic draw;       // advance generator and tick
        logic mix;        // form draw, update pink bank, brown increment
        logic walk;       // brown walk, pink quotient
        logic value;      // select colored value
        logic scale;      // gain multiply
        logic pcm;        // clamp and PCM conversion
        logic clear_pcm;  // silent result for the unused color
        logic out_load;   // move result to output register
    } t_cmd;

    typedef struct packed {
        logic color_none;
    } t_stat;

endpackage

FILE: rtl/cng_if.sv
// ----------------------------------------------------------------------------
// cng_if
// Request channels of the colored noise generator: input, output, config.
// ----------------------------------------------------------------------------
interface cng_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface cng_out_if;
    import cng_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;

    modport source (output valid, output sample, output clipped, input ready);
    modport sink   (input valid, input sample, input clipped, output ready);
endinterface

interface cng_cfg_if;
    import cng_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/colored_noise_generator.sv
// ----------------------------------------------------------------------------
// colored_noise_generator
// White, pink (Voss-McCartney) and brown noise from a 32-bit LCG, scaled by a
// Q16 gain and converted to 16-bit PCM.
// ----------------------------------------------------------------------------
//  channel   dir   payload                 accepted when
//  i_in      in    restart                 valid && ready
//  o_out     out   sample[15:0], clipped   valid && ready
//  i_cfg     in    index[1:0], data[31:0]  valid && ready (ready always high)
//
//  A request passes from acceptance to the output register through draw, mix,
//  walk/divide, value, gain, PCM and load; the unused color skips to load.
//  No new request is taken until the last result is in the output register.
//  The next request is taken while a result waits in the output register;
//  a stalled output holds the sequencer in its final step.
//  Synchronous active-low reset; all noise state resets at once.
// ----------------------------------------------------------------------------
module colored_noise_generator #(
    parameter int PINK_ROWS = 7
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cng_in_if.sink    i_in,
    cng_out_if.source o_out,
    cng_cfg_if.sink   i_cfg
);
    import cng_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    cng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cng_datapath #(
        .PINK_ROWS (PINK_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_restart   (i_in.restart),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_sample    (o_out.sample),
        .o_clipped   (o_out.clipped)
    );

endmodule

FILE: rtl/cng_ctrl.sv
// ----------------------------------------------------------------------------
// cng_ctrl
// Sequencer: takes one request, steps the datapath through its stages and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module cng_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  cng_pkg::t_stat i_stat,
    output cng_pkg::t_cmd  o_cmd
);
    import cng_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DRAW  = 3'd1;
    localparam logic [2:0] ST_MIX   = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_VALUE = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_PCM   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (i_stat.color_none) begin
                    o_cmd.clear_pcm = 1'b1;
                    n_state         = ST_OUT;
                end else begin
                    o_cmd.draw = 1'b1;
                    n_state    = ST_MIX;
                end
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                n_state    = ST_VALUE;
            end
            ST_VALUE: begin
                o_cmd.value = 1'b1;
                n_state     = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_PCM;
            end
            ST_PCM: begin
                o_cmd.pcm = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register can take the result
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/cng_datapath.sv
// ----------------------------------------------------------------------------
// cng_datapath
// Config registers, generator, pink bank, brown walk, gain and PCM stages,
// output payload register.
// ----------------------------------------------------------------------------
module cng_datapath #(
    parameter int PINK_ROWS = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [cng_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cng_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_restart,
    input  cng_pkg::t_cmd                        i_cmd,
    output cng_pkg::t_stat                       o_stat,
    output logic signed [cng_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                                 o_clipped
);
    import cng_pkg::*;

    localparam int IDX_W   = $clog2(PINK_ROWS);
    localparam int TOT_W   = DRAW_W + IDX_W;
    // reciprocal of PINK_ROWS, exact for magnitudes below 2^TOT_W
    localparam int SHIFT   = TOT_W + IDX_W;
    localparam int RECIP_W = TOT_W + 1;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / PINK_ROWS) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W  = TOT_W + RECIP_W;

    localparam logic signed [WALK_W:0] FS_SUM  = (WALK_W+1)'(1 << 24);
    localparam logic signed [U_W-1:0]  FS_U    = U_W'(1 << 24);
    localparam logic signed [41:0]     PCM_RND = 42'sd16777215;

    // configuration
    logic [COLOR_W-1:0] r_color;
    logic [SEED_W-1:0]  r_seed;
    logic [AMP_W-1:0]   r_amp;

    // noise state
    logic [SEED_W-1:0]        r_lcg;
    logic signed [DRAW_W-1:0] r_row [PINK_ROWS];
    logic signed [TOT_W-1:0]  r_total;
    logic [PINK_ROWS-1:0]     r_tick;
    logic signed [WALK_W-1:0] r_walk;

    // stage registers
    logic signed [DRAW_W-1:0]   r_draw;
    logic signed [STEP_W-1:0]   r_step;
    logic [QUOT_W-1:0]          r_quot;
    logic                       r_neg;
    logic signed [V_W-1:0]      r_v;
    logic signed [U_W-1:0]      r_u;
    logic signed [SAMPLE_W-1:0] r_pcm;
    logic                       r_clip;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_clipped;

    logic                       is_pink, is_brown;
    logic signed [DRAW_W-1:0]   draw_now;
    logic [IDX_W-1:0]           row_idx;
    logic signed [TOT_W-1:0]    total_next;
    logic signed [40:0]         step_prod;
    logic signed [WALK_W:0]     walk_sum;
    logic signed [WALK_W-1:0]   walk_next;
    logic [TOT_W-1:0]           total_mag;
    logic [PROD_W-1:0]          quot_prod;
    logic signed [V_W-1:0]      v_next;
    logic signed [AMP_W:0]      amp_s;
    logic signed [44:0]         scale_prod;
    logic signed [UC_W-1:0]     u_clamp;
    logic                       u_over;
    logic signed [41:0]         pcm_prod;
    logic signed [41:0]         pcm_adj;
    logic [SEED_W-1:0]          lcg_next;

    assign is_pink  = (r_color == COLOR_PINK);
    assign is_brown = (r_color == COLOR_BROWN);
    assign o_stat.color_none = (r_color == COLOR_NONE);

    assign lcg_next = SEED_W'(r_lcg * LCG_MUL) + LCG_INC;

    // r = 2*(x>>8) - 2^24: subtracting 2^24 flips the top bit
    assign draw_now = {~r_lcg[31], r_lcg[30:8], 1'b0};

    // trailing zeros of the tick, capped at the last row
    always_comb begin
        row_idx = IDX_W'(PINK_ROWS - 1);
        for (int k = PINK_ROWS - 2; k >= 0; k--) begin
            if (r_tick[k]) begin
                row_idx = IDX_W'(k);
            end
        end
    end

    assign total_next = r_total - TOT_W'(r_row[row_idx]) + TOT_W'(draw_now);

    assign step_prod = draw_now * BROWN_GAIN;

    assign walk_sum = (WALK_W+1)'(r_walk) + (WALK_W+1)'(r_step);
    always_comb begin
        if (walk_sum > FS_SUM) begin
            walk_next = WALK_W'(FS_SUM);
        end else if (walk_sum < -FS_SUM) begin
            walk_next = WALK_W'(-FS_SUM);
        end else begin
            walk_next = walk_sum[WALK_W-1:0];
        end
    end

    assign total_mag = r_total[TOT_W-1] ? (~r_total + TOT_W'(1)) : r_total;
    assign quot_prod = PROD_W'(total_mag) * PROD_W'(RECIP);

    always_comb begin
        case (r_color)
            COLOR_PINK:  v_next = r_neg ? -V_W'({1'b0, r_quot}) : V_W'({1'b0, r_quot});
            COLOR_BROWN: v_next = V_W'(r_walk) + (V_W'(r_walk) <<< 1);
            default:     v_next = V_W'(r_draw);
        endcase
    end

    assign amp_s      = $signed({1'b0, r_amp});
    assign scale_prod = r_v * amp_s;

    always_comb begin
        u_over = 1'b1;
        if (r_u > FS_U) begin
            u_clamp = UC_W'(FS_U);
        end else if (r_u < -FS_U) begin
            u_clamp = UC_W'(-FS_U);
        end else begin
            u_clamp = r_u[UC_W-1:0];
            u_over  = 1'b0;
        end
    end

    assign pcm_prod = u_clamp * PCM_GAIN;
    // truncate toward zero
    assign pcm_adj  = pcm_prod[41] ? (pcm_prod + PCM_RND) : pcm_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_WHITE;
            r_seed  <= SEED_RESET;
            r_amp   <= AMP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COLOR: r_color <= i_cfg_data[COLOR_W-1:0];
                CFG_SEED:  r_seed  <= i_cfg_data[SEED_W-1:0];
                CFG_AMP:   r_amp   <= i_cfg_data[AMP_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg   <= SEED_RESET;
            r_total <= '0;
            r_tick  <= '0;
            r_walk  <= '0;
            for (int k = 0; k < PINK_ROWS; k++) begin
                r_row[k] <= '0;
            end
        end else if (i_cmd.load) begin
            if (i_restart) begin
                r_lcg   <= (r_seed == '0) ? SEED_W'(1) : r_seed;
                r_total <= '0;
                r_tick  <= '0;
                r_walk  <= '0;
                for (int k = 0; k < PINK_ROWS; k++) begin
                    r_row[k] <= '0;
                end
            end
        end else begin
            if (i_cmd.draw) begin
                r_lcg <= lcg_next;
                if (is_pink) begin
                    r_tick <= r_tick + PINK_ROWS'(1);
                end
            end
            if (i_cmd.mix && is_pink) begin
                r_total        <= total_next;
                r_row[row_idx] <= draw_now;
            end
            if (i_cmd.walk && is_brown) begin
                r_walk <= walk_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_draw <= draw_now;
            r_step <= step_prod[16 +: STEP_W];
        end
        if (i_cmd.walk) begin
            r_quot <= quot_prod[SHIFT +: QUOT_W];
            r_neg  <= r_total[TOT_W-1];
        end
        if (i_cmd.value) begin
            r_v <= v_next;
        end
        if (i_cmd.scale) begin
            r_u <= scale_prod[16 +: U_W];
        end
        if (i_cmd.pcm) begin
            r_pcm  <= pcm_adj[24 +: SAMPLE_W];
            r_clip <= u_over;
        end else if (i_cmd.clear_pcm) begin
            r_pcm  <= '0;
            r_clip <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_sample  <= r_pcm;
            r_clipped <= r_clip;
        end
    end

    assign o_sample  = r_sample;
    assign o_clipped = r_clipped;

endmodule

FILE: dv/cng_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cng_checker
// Watches the input, output and config channels of the colored noise
// generator, keeps its own copy of the LCG, pink bank and brown walk, and
// checks every output request against the predicted PCM sample.
// ----------------------------------------------------------------------------
module cng_checker #(
    parameter int PINK_ROWS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_in_restart,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [cng_pkg::SAMPLE_W-1:0] i_out_sample,
    input  logic                                i_out_clipped,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [cng_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cng_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);
    import cng_pkg::*;

    localparam longint FULL_SCALE = 64'sd16777216;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                clipped;
    } t_pcm;

    // register copies
    logic [COLOR_W-1:0] color_reg;
    logic [SEED_W-1:0]  seed_reg;
    logic [AMP_W-1:0]   amp_reg;

    // noise state
    logic [31:0]               lcg;
    logic signed [DRAW_W-1:0]  bank [PINK_ROWS];
    logic signed [DRAW_W+4:0]  bank_sum;
    logic [PINK_ROWS-1:0]      tick;
    logic signed [WALK_W-1:0]  walk;

    t_pcm pending_pcm [$];
    int   mismatches;

    function automatic longint floor16(longint p);
        return p >>> 16;
    endfunction

    function automatic longint clamp_full(longint p);
        if (p > FULL_SCALE) return FULL_SCALE;
        if (p < -FULL_SCALE) return -FULL_SCALE;
        return p;
    endfunction

    function automatic longint next_draw();
        lcg = lcg * 32'd1664525 + 32'd1013904223;
        return 2 * longint'(lcg[31:8]) - FULL_SCALE;
    endfunction

    function automatic void reseed();
        lcg = (seed_reg == '0) ? 32'd1 : seed_reg;
        for (int k = 0; k < PINK_ROWS; k++) bank[k] = '0;
        bank_sum = '0;
        tick     = '0;
        walk     = '0;
    endfunction

    function automatic t_pcm next_pcm(logic restart);
        longint               v;
        longint               u;
        longint               r;
        int                   row;
        logic [PINK_ROWS-1:0] t;
        t_pcm                 res;
        res = '0;
        if (restart) reseed();
        case (color_reg)
            COLOR_WHITE: v = next_draw();
            COLOR_PINK: begin
                tick = tick + PINK_ROWS'(1);
                t    = tick;
                row  = 0;
                // trailing zeros of the tick pick the row; zero tick lands on the top row
                while (row < PINK_ROWS - 1 && !t[0]) begin
                    t = t >> 1;
                    row++;
                end
                r         = next_draw();
                bank_sum  = (DRAW_W+5)'(longint'(bank_sum) - longint'(bank[row]) + r);
                bank[row] = DRAW_W'(r);
                v = longint'(bank_sum) / PINK_ROWS;
            end
            COLOR_BROWN: begin
                walk = WALK_W'(clamp_full(longint'(walk) + floor16(next_draw() * 6554)));
                v    = 3 * longint'(walk);
            end
            default: return res;  // unused color: silent, state untouched apart from a restart
        endcase
        u = floor16(v * longint'({15'd0, amp_reg}));
        res.clipped = (u > FULL_SCALE) || (u < -FULL_SCALE);
        u = clamp_full(u);
        res.sample = SAMPLE_W'((u * 32767) / FULL_SCALE);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pcm want;
        if (!i_rst_n) begin
            color_reg = COLOR_WHITE;
            seed_reg  = SEED_RESET;
            amp_reg   = AMP_RESET;
            reseed();
            pending_pcm.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COLOR: color_reg = i_cfg_data[COLOR_W-1:0];
                    CFG_SEED:  seed_reg  = i_cfg_data[SEED_W-1:0];
                    CFG_AMP:   amp_reg   = i_cfg_data[AMP_W-1:0];
                    default: ;
                endcase
            end
            // retire the oldest prediction before queueing a new one
            if (i_out_valid && i_out_ready) begin
                if (pending_pcm.size() == 0) begin
                    $error("unexpected result: sample %0d clipped %0b",
                           i_out_sample, i_out_clipped);
                    mismatches++;
                end else begin
                    want = pending_pcm.pop_front();
                    if (want.sample !== i_out_sample) begin
                        $error("sample mismatch: expected %0d, got %0d",
                               $signed(want.sample), i_out_sample);
                        mismatches++;
                    end
                    if (want.clipped !== i_out_clipped) begin
                        $error("clipped mismatch: expected %0b, got %0b",
                               want.clipped, i_out_clipped);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) pending_pcm.push_back(next_pcm(i_in_restart));
        end
        o_errors  <= mismatches;
        o_pending <= pending_pcm.size();
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the colored noise generator bench: drives config writes and noise
// requests with random gaps and output stalls, one long output hold-off, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import cng_pkg::*;

    localparam int PINK_ROWS       = 7;
    localparam int RANDOM_ITEMS    = 1650;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cng_in_if  in_if ();
    cng_out_if out_if ();
    cng_cfg_if cfg_if ();

    int fail_count;
    int queued;
    int sent_count;
    int restart_count;
    int setting_count;

    colored_noise_generator #(.PINK_ROWS(PINK_ROWS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    cng_checker #(.PINK_ROWS(PINK_ROWS)) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_if.valid),
        .i_in_ready    (in_if.ready),
        .i_in_restart  (in_if.restart),
        .i_out_valid   (out_if.valid),
        .i_out_ready   (out_if.ready),
        .i_out_sample  (out_if.sample),
        .i_out_clipped (out_if.clipped),
        .i_cfg_valid   (cfg_if.valid),
        .i_cfg_ready   (cfg_if.ready),
        .i_cfg_index   (cfg_if.index),
        .i_cfg_data    (cfg_if.data),
        .o_errors      (fail_count),
        .o_pending     (queued)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_request(input logic restart, input int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.restart <= restart;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_count++;
        if (restart) restart_count++;
    endtask

    // one extra edge first so a request taken on this edge is already counted
    task automatic wait_drained();
        @(posedge i_clk);
        while (queued != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] color_data,
                             input logic [CFG_DATA_W-1:0] seed_data,
                             input logic [CFG_DATA_W-1:0] amp_data,
                             input int n, input logic first_restart,
                             input int restart_odds, input bit gapless,
                             input bit poke_unused);
        logic restart;
        wait_drained();
        write_reg(CFG_COLOR, color_data);
        write_reg(CFG_SEED, seed_data);
        write_reg(CFG_AMP, amp_data);
        if (poke_unused) write_reg(CFG_UNUSED, $urandom());
        cfg_if.valid <= 1'b0;
        setting_count++;
        for (int i = 0; i < n; i++) begin
            restart = (i == 0) ? first_restart : ($urandom_range(1, restart_odds) == 1);
            send_request(restart, gapless ? 0 : pick_gap());
        end
        in_if.valid <= 1'b0;
    endtask

    // output side: random stalls, calm stretches, one long hold-off to back up the input
    initial begin : sink_side
        int  stall;
        int  calm;
        int  roll;
        bit  held;
        stall = 0;
        calm  = 0;
        held  = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_count >= PRESSURE_AT) begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
            end else if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                out_if.ready <= 1'b1;
                if (calm > 0) begin
                    calm--;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3) calm = $urandom_range(50, 200);
                    else if (roll < 70) stall = 0;
                    else if (roll < 95) stall = $urandom_range(1, 3);
                    else stall = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                    || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int         roll;
        int         n;
        logic [1:0] color;
        logic [31:0] seed;
        logic [16:0] amp;
        sent_count    = 0;
        restart_count = 0;
        setting_count = 0;
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.restart  <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= CFG_COLOR;
        cfg_if.data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset defaults, first request without restart
        send_request(1'b0, 0);
        send_request(1'b1, 0);
        send_request(1'b0, 2);
        in_if.valid <= 1'b0;

        // zero seed at full-scale gain
        run_phase({30'd0, COLOR_WHITE}, 32'd0, 32'd65536, 3, 1'b1, 1000, 1'b1, 1'b0);
        // pink with all-ones seed and smallest nonzero gain
        run_phase({30'd0, COLOR_PINK}, 32'hFFFF_FFFF, 32'd1, 8, 1'b1, 1000, 1'b1, 1'b0);
        // brown with maximum gain, junk above the fields, drives the clamp
        run_phase(32'hFFFF_FFFE, 32'h1234_5678, 32'hFFFF_FFFF, 6, 1'b1, 1000, 1'b0, 1'b1);
        // unused color, restart still applies
        run_phase(32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0000_8000, 2, 1'b1, 1000, 1'b0, 1'b0);
        // zero gain gives silence
        run_phase({30'd0, COLOR_WHITE}, 32'd7, 32'hFFFE_0000, 2, 1'b0, 1000, 1'b1, 1'b0);
        // back to pink mid-stream, bank kept
        run_phase({30'd0, COLOR_PINK}, 32'd9, 32'd32768, 1, 1'b0, 1000, 1'b0, 1'b0);

        while (sent_count < 25 + RANDOM_ITEMS) begin
            roll  = $urandom_range(0, 99);
            color = (roll < 92) ? 2'($urandom_range(0, 2)) : COLOR_NONE;
            roll  = $urandom_range(0, 99);
            seed  = (roll < 10) ? 32'd0 : (roll < 15) ? 32'hFFFF_FFFF : 32'($urandom());
            roll  = $urandom_range(0, 99);
            if (roll < 10) amp = 17'd65536;
            else if (roll < 15) amp = 17'd1;
            else if (roll < 20) amp = 17'd0;
            else if (roll < 35) amp = 17'($urandom_range(65537, 131071));
            else amp = 17'($urandom_range(1, 65536));
            // long runs let the pink tick wrap and the walk reach its rails
            n = ($urandom_range(0, 99) < 80) ? $urandom_range(10, 80) : $urandom_range(130, 300);
            if (n > 25 + RANDOM_ITEMS - sent_count) n = 25 + RANDOM_ITEMS - sent_count;
            run_phase({30'($urandom() >> 2), color}, seed, {15'($urandom()), amp}, n,
                      1'($urandom_range(0, 1)), $urandom_range(8, 60),
                      $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d noise requests (%0d with restart) over %0d register settings,",
                 sent_count, restart_count, setting_count);
        $display("all colors and gain extremes, with a %0d-cycle output hold-off",
                 PRESSURE_CYCLES);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
